### design/utf8_to_gb2312_stream_macros.svh
// Assertion macros for the UTF-8 to GB2312 stream converter.
// Expects signals clk and arst_n in the scope of use.
`ifndef UTF8_TO_GB2312_STREAM_MACROS_SVH
`define UTF8_TO_GB2312_STREAM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define U2G_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define U2G_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/u2g_pkg.sv
// Shared constants, types and helper function for the UTF-8 to GB2312 converter.
// No dependencies.
package u2g_pkg;

	localparam int TABLE_DEPTH = 8192;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int CFG_W       = 14;
	localparam int IDX_W       = 13;
	localparam int KEY_W       = 16;
	localparam int CODE_W      = 16;

	// Input command codes
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	localparam logic [7:0] LEAD3_MASK  = 8'h0F;
	localparam logic [7:0] MID_MASK    = 8'h03;
	localparam logic [7:0] TRAIL_MASK  = 8'h3F;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [KEY_W-1:0]  key;
		logic [CODE_W-1:0] code;
	} tbl_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} tbl_rd_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [CODE_W-1:0] code;
	} tbl_ent_t;

	typedef struct packed {
		logic             start;
		logic [KEY_W-1:0] key;
	} srch_req_t;

	typedef struct packed {
		logic              done;
		logic              hit;
		logic [CODE_W-1:0] code;
	} srch_rsp_t;

	// Count leading one bits of a byte (0 to 8).
	function automatic logic [3:0] lead_ones(input logic [7:0] b);
		logic [3:0] n;
		logic       run;
		n   = 4'd0;
		run = 1'b1;
		for (int i = 7; i >= 0; i--) begin
			if (run && b[i]) begin
				n = n + 4'd1;
			end else begin
				run = 1'b0;
			end
		end
		return n;
	endfunction

endpackage

### design/u2g_table.sv
// Code table storage: key and GB2312 code per entry, one write and one read port.
// Depends on u2g_pkg. Read data is registered; contents undefined until written.
module u2g_table (
	input  logic              clk,
	input  u2g_pkg::tbl_wr_t  wr,
	input  u2g_pkg::tbl_rd_t  rd,
	output u2g_pkg::tbl_ent_t rd_data
);
	import u2g_pkg::*;

	logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
	logic [CODE_W-1:0] code_mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			key_mem[wr.addr]  <= wr.key;
			code_mem[wr.addr] <= wr.code;
		end
		if (rd.en) begin
			rd_data.key  <= key_mem[rd.addr];
			rd_data.code <= code_mem[rd.addr];
		end
	end

endmodule

### design/u2g_search.sv
// Binary search sequencer over the code table: one shared compare, a probe state then a compare state per probe.
// Depends on u2g_pkg; drives the read port of u2g_table.
module u2g_search (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [u2g_pkg::CFG_W-1:0]    entries_in_use,
	input  u2g_pkg::srch_req_t           req,
	output u2g_pkg::srch_rsp_t           rsp,
	output u2g_pkg::tbl_rd_t             rd,
	input  u2g_pkg::tbl_ent_t            rd_data
);
	import u2g_pkg::*;

	typedef enum logic [1:0] {SR_IDLE, SR_PROBE, SR_CMP} sr_state_t;

	sr_state_t         state_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;   // one past the last candidate
	logic [ADDR_W-1:0] mid_q;
	logic [KEY_W-1:0]  key_q;
	logic [CNT_W-1:0]  n_lim;
	logic [CNT_W:0]    sum;
	logic [ADDR_W-1:0] mid;

	// Clamp the entry count to the table depth.
	assign n_lim = (32'(entries_in_use) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
	                                                    : CNT_W'(entries_in_use);
	assign sum   = {1'b0, lo_q} + {1'b0, hi_q} - (CNT_W+1)'(1);
	assign mid   = ADDR_W'(sum >> 1);

	assign rd.en   = (state_q == SR_PROBE) && (lo_q < hi_q);
	assign rd.addr = mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SR_IDLE;
			rsp.done <= 1'b0;
			rsp.hit  <= 1'b0;
			rsp.code <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			mid_q    <= '0;
			key_q    <= '0;
		end else begin
			rsp.done <= 1'b0;
			case (state_q)
				SR_IDLE: begin
					if (req.start) begin
						lo_q    <= '0;
						hi_q    <= n_lim;
						key_q   <= req.key;
						state_q <= SR_PROBE;
					end
				end
				SR_PROBE: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= SR_CMP;
					end else begin
						// Range empty: miss
						rsp.done <= 1'b1;
						rsp.hit  <= 1'b0;
						rsp.code <= '0;
						state_q  <= SR_IDLE;
					end
				end
				SR_CMP: begin
					if (rd_data.key == key_q) begin
						rsp.done <= 1'b1;
						rsp.hit  <= 1'b1;
						rsp.code <= rd_data.code;
						state_q  <= SR_IDLE;
					end else if (rd_data.key > key_q) begin
						hi_q    <= CNT_W'(mid_q);
						state_q <= SR_PROBE;
					end else begin
						lo_q    <= CNT_W'(mid_q) + CNT_W'(1);
						state_q <= SR_PROBE;
					end
				end
				default: begin
					state_q <= SR_IDLE;
				end
			endcase
		end
	end

endmodule

### design/utf8_to_gb2312_stream.sv
// UTF-8 to GB2312 stream converter, top level. The results of a byte appear on the
// master side the cycle after its input transaction; the final byte of a three-byte sequence
// first runs a table search of at most 14 probes for 8192 entries, each probe a table read
// and then a compare. Input waits while a search runs and while the result buffer drains;
// a table load leaves the input ready. Reset clears all but the table, which has no
// clearing pass.
`include "utf8_to_gb2312_stream_macros.svh"

module utf8_to_gb2312_stream (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration: entries_in_use
	input  logic                      cfg_we,
	input  logic [u2g_pkg::CFG_W-1:0] cfg_wdata,
	// Input stream
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [55:0]               s_tdata,  // data_byte[7:0], entry_index[20:8],
	                                            // entry_key[36:21], entry_value[52:37], zero pad
	input  logic                      s_tuser,  // command (0 data byte, 1 table load)
	input  logic                      s_tlast,  // last_byte
	// Output stream
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,  // out_byte
	output logic [1:0]                m_tuser,  // not_found[0], end_of_string[1]
	output logic                      m_tlast   // last_of_run
);
	import u2g_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_EMIT} state_t;
	typedef enum logic [1:0] {MD_IDLE, MD_TWO, MD_THREE, MD_SKIP} mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       nf;
		logic       eos;
	} res_t;

	// Input field views
	logic [7:0]       in_byte;
	logic [IDX_W-1:0] in_index;
	logic [KEY_W-1:0] in_key;
	logic [CODE_W-1:0] in_value;
	logic             s_acc;
	logic             m_acc;

	assign in_byte  = s_tdata[7:0];
	assign in_index = s_tdata[20:8];
	assign in_key   = s_tdata[36:21];
	assign in_value = s_tdata[52:37];
	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = m_tvalid && m_tready;

	// Registers
	state_t           state_q;
	mode_t            mode_q;
	logic [2:0]       left_q;
	logic [KEY_W-1:0] part_q;
	logic [CFG_W-1:0] cfg_q;
	logic             last_q;    // terminator owed after the search
	res_t             buf_q [3];
	logic [1:0]       cnt_q;
	logic [1:0]       ptr_q;

	// Sub-unit links
	tbl_wr_t   tbl_wr;
	tbl_rd_t   tbl_rd;
	tbl_ent_t  tbl_data;
	srch_req_t srch_req;
	srch_rsp_t srch_rsp;

	// Decode of one data byte against the sequence state
	mode_t            d_mode;
	logic [2:0]       d_left;
	logic [KEY_W-1:0] d_part;
	logic [1:0]       d_cnt;
	res_t             d_res [3];
	logic             d_search;
	logic [KEY_W-1:0] d_key;
	logic [3:0]       ones;

	always_comb begin
		d_mode   = mode_q;
		d_left   = left_q;
		d_part   = part_q;
		d_cnt    = 2'd0;
		d_search = 1'b0;
		d_key    = part_q + {8'h00, in_byte & TRAIL_MASK};
		ones     = lead_ones(in_byte);
		for (int i = 0; i < 3; i++) begin
			d_res[i] = '0;
		end
		case (mode_q)
			MD_IDLE: begin
				if (ones == 4'd0) begin
					// ASCII, including zero: pass through
					d_res[0] = '{data: in_byte, nf: 1'b0, eos: 1'b0};
					d_cnt    = 2'd1;
				end else if (ones == 4'd2) begin
					d_mode = MD_TWO;
					d_left = 3'd1;
					d_part = {8'h00, in_byte};
				end else if (ones == 4'd3) begin
					d_mode = MD_THREE;
					d_left = 3'd2;
					d_part = {in_byte[3:0] & LEAD3_MASK[3:0], 12'h000};
				end else if (ones >= 4'd4 && ones <= 4'd6) begin
					d_mode = MD_SKIP;
					d_left = 3'(ones - 4'd1);
				end
			end
			MD_TWO: begin
				// Copy the pair out unchanged
				d_res[0] = '{data: part_q[7:0], nf: 1'b0, eos: 1'b0};
				d_res[1] = '{data: in_byte, nf: 1'b0, eos: 1'b0};
				d_cnt    = 2'd2;
				d_mode   = MD_IDLE;
				d_left   = 3'd0;
				d_part   = '0;
			end
			MD_THREE: begin
				if (left_q == 3'd2) begin
					d_part = part_q | {4'h0, in_byte[5:2], in_byte[1:0] & MID_MASK[1:0], 6'h00};
					d_left = 3'd1;
				end else begin
					d_search = 1'b1;
					d_mode   = MD_IDLE;
					d_left   = 3'd0;
					d_part   = '0;
				end
			end
			MD_SKIP: begin
				if (left_q != 3'd0) begin
					d_left = left_q - 3'd1;
				end
				if (d_left == 3'd0) begin
					d_mode = MD_IDLE;
				end
			end
			default: begin
				d_mode = MD_IDLE;
			end
		endcase
		if (s_tlast) begin
			// Drop any unfinished sequence
			d_mode = MD_IDLE;
			d_left = 3'd0;
			d_part = '0;
			if (!d_search) begin
				d_res[d_cnt] = '{data: 8'h00, nf: 1'b0, eos: 1'b1};
				d_cnt        = d_cnt + 2'd1;
			end
		end
	end

	// Table load and search request
	assign tbl_wr.en   = s_acc && (s_tuser == CMD_LOAD) && (32'(in_index) < TABLE_DEPTH);
	assign tbl_wr.addr = ADDR_W'(in_index);
	assign tbl_wr.key  = in_key;
	assign tbl_wr.code = in_value;

	assign srch_req.start = s_acc && (s_tuser == CMD_DATA) && d_search;
	assign srch_req.key   = d_key;

	u2g_table u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd      (tbl_rd),
		.rd_data (tbl_data)
	);

	u2g_search u_search (
		.clk            (clk),
		.arst_n         (arst_n),
		.entries_in_use (cfg_q),
		.req            (srch_req),
		.rsp            (srch_rsp),
		.rd             (tbl_rd),
		.rd_data        (tbl_data)
	);

	// Handshake and result view
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tdata  = buf_q[ptr_q].data;
	assign m_tuser  = {buf_q[ptr_q].eos, buf_q[ptr_q].nf};
	assign m_tlast  = (ptr_q == cnt_q - 2'd1);

	// Sequencer: hold state, sequence context and the result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MD_IDLE;
			left_q  <= 3'd0;
			part_q  <= '0;
			cfg_q   <= '0;
			last_q  <= 1'b0;
			cnt_q   <= 2'd0;
			ptr_q   <= 2'd0;
			for (int i = 0; i < 3; i++) begin
				buf_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc && (s_tuser == CMD_DATA)) begin
						mode_q <= d_mode;
						left_q <= d_left;
						part_q <= d_part;
						last_q <= s_tlast;
						buf_q  <= d_res;
						cnt_q  <= d_cnt;
						ptr_q  <= 2'd0;
						if (d_search) begin
							state_q <= ST_SEARCH;
						end else if (d_cnt != 2'd0) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_SEARCH: begin
					if (srch_rsp.done) begin
						// High byte first; a miss gives zero bytes flagged
						buf_q[0] <= '{data: srch_rsp.code[15:8], nf: !srch_rsp.hit, eos: 1'b0};
						buf_q[1] <= '{data: srch_rsp.code[7:0], nf: !srch_rsp.hit, eos: 1'b0};
						buf_q[2] <= '{data: 8'h00, nf: 1'b0, eos: 1'b1};
						cnt_q    <= last_q ? 2'd3 : 2'd2;
						ptr_q    <= 2'd0;
						state_q  <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (m_acc) begin
						if (m_tlast) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q <= ptr_q + 2'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks
	`U2G_ASSERT_IMP(a_no_accept_while_emit, m_tvalid, !s_tready, "input taken during emit")
	`U2G_ASSERT_IMP(a_done_only_in_search, srch_rsp.done, state_q == ST_SEARCH, "stray search done")
	`U2G_ASSERT_IMP(a_term_is_last, m_tvalid && m_tuser[1], m_tlast, "terminator not last of run")
	`U2G_ASSERT_NXT(a_load_returns, s_acc && (s_tuser == CMD_LOAD), s_tready, "table load stalled the input")

endmodule

### dv/utf8_to_gb2312_stream_test.sv
// Self-checking testbench for utf8_to_gb2312_stream: fills the code table, streams UTF-8
// bytes with random gaps and stalls, and checks every output transaction in order.
// Depends on u2g_pkg and the utf8_to_gb2312_stream design sources.
`timescale 1ns / 1ps

module utf8_to_gb2312_stream_test;
	import u2g_pkg::*;

	// Cycles to let a table search finish once the last expected byte is out
	localparam int SEARCH_SLACK = 40;
	// Cycles with no transaction on either side before the run is abandoned
	localparam int STALL_LIMIT  = 3000;
	localparam int PHASE_ITEMS  = 43;
	// Low table entries loaded with sorted keys; searches in the random part stay inside them
	localparam int FILL_ENTRIES = 64;
	localparam int ZERO_SLOT    = 20;

	typedef enum logic [1:0] {SEQ_IDLE, SEQ_TWO, SEQ_THREE, SEQ_SKIP} seq_state_t;

	typedef struct packed {
		logic [7:0] octet;
		logic       miss;
		logic       run_end;
		logic       str_end;
	} gb_out_t;

	// Tracks the converter: its code table, sequence state and entry count, and the
	// output bytes still owed.
	class gb_scoreboard_t;
		logic [KEY_W-1:0]  keys  [TABLE_DEPTH];
		logic [CODE_W-1:0] codes [TABLE_DEPTH];
		logic [CFG_W-1:0]  entries;
		seq_state_t        state;
		logic [2:0]        bytes_owed;
		logic [15:0]       partial;
		gb_out_t           due [$];
		int                errors;

		function new();
			entries    = '0;
			state      = SEQ_IDLE;
			bytes_owed = '0;
			partial    = '0;
			errors     = 0;
		endfunction

		function int span();
			return (entries > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries);
		endfunction

		function int lead_count(logic [7:0] b);
			int n;
			n = 0;
			while (n < 8 && b[7-n])
				n++;
			return n;
		endfunction

		function bit search(logic [15:0] key, output logic [CODE_W-1:0] code);
			int lo, hi, mid;
			lo   = 0;
			hi   = span() - 1;
			code = '0;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				if (keys[mid] == key) begin
					code = codes[mid];
					return 1'b1;
				end else if (keys[mid] > key) begin
					hi = mid - 1;
				end else begin
					lo = mid + 1;
				end
			end
			return 1'b0;
		endfunction

		function void push(logic [7:0] o, logic m, logic e);
			gb_out_t r;
			r = '{o, m, 1'b0, e};
			due.push_back(r);
		endfunction

		function void absorb(logic cmd, logic [7:0] b, logic last, logic [IDX_W-1:0] idx,
				logic [KEY_W-1:0] key, logic [CODE_W-1:0] val);
			int               ones;
			int               made;
			logic [CODE_W-1:0] code;
			bit               hit;
			if (cmd == CMD_LOAD) begin
				keys[idx]  = key;
				codes[idx] = val;
				return;
			end
			made = due.size();
			case (state)
				SEQ_IDLE: begin
					ones = lead_count(b);
					if (ones == 0) begin
						push(b, 1'b0, 1'b0);
					end else if (ones == 2) begin
						state      = SEQ_TWO;
						bytes_owed = 3'd1;
						partial    = {8'h00, b};
					end else if (ones == 3) begin
						state      = SEQ_THREE;
						bytes_owed = 3'd2;
						partial    = {b[3:0], 12'h000};
					end else if (ones >= 4 && ones <= 6) begin
						state      = SEQ_SKIP;
						bytes_owed = 3'(ones - 1);
					end
				end
				SEQ_TWO: begin
					push(partial[7:0], 1'b0, 1'b0);
					push(b, 1'b0, 1'b0);
					state      = SEQ_IDLE;
					bytes_owed = '0;
					partial    = '0;
				end
				SEQ_THREE: begin
					if (bytes_owed == 3'd2) begin
						partial[11:6] = b[5:0];
						bytes_owed    = 3'd1;
					end else begin
						partial = partial + {10'd0, b[5:0]};
						hit     = search(partial, code);
						push(code[15:8], !hit, 1'b0);
						push(code[7:0], !hit, 1'b0);
						state      = SEQ_IDLE;
						bytes_owed = '0;
						partial    = '0;
					end
				end
				default: begin
					if (bytes_owed != 0)
						bytes_owed--;
					if (bytes_owed == 0)
						state = SEQ_IDLE;
				end
			endcase
			if (last) begin
				state      = SEQ_IDLE;
				bytes_owed = '0;
				partial    = '0;
				push(8'h00, 1'b0, 1'b1);
			end
			if (due.size() > made)
				due[due.size()-1].run_end = 1'b1;
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("mismatch: %s", what);
		endtask

		task compare(gb_out_t got);
			gb_out_t want;
			if (due.size() == 0) begin
				report_mismatch($sformatf("unexpected result, byte %02h", got.octet));
				return;
			end
			want = due.pop_front();
			if (got.octet != want.octet)
				report_mismatch($sformatf("out_byte %02h, expected %02h", got.octet, want.octet));
			if (got.miss != want.miss)
				report_mismatch($sformatf("not_found %0b, expected %0b", got.miss, want.miss));
			if (got.run_end != want.run_end)
				report_mismatch($sformatf("last_of_run %0b, expected %0b (byte %02h)",
					got.run_end, want.run_end, want.octet));
			if (got.str_end != want.str_end)
				report_mismatch($sformatf("end_of_string %0b, expected %0b",
					got.str_end, want.str_end));
		endtask

		function int waiting();
			return due.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_W-1:0]  cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [55:0]       s_tdata;   // data_byte[7:0], entry_index[20:8], entry_key[36:21],
	                              // entry_value[52:37], zero pad
	logic              s_tuser;   // command
	logic              s_tlast;   // last_byte
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;   // out_byte
	logic [1:0]        m_tuser;   // not_found[0], end_of_string[1]
	logic              m_tlast;   // last_of_run

	gb_scoreboard_t tracker;
	int src_idle_pct = 14;
	int snk_idle_pct = 71;
	int last_pct     = 0;
	int items_sent   = 0;

	utf8_to_gb2312_stream u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Output side: check each accepted transaction, then decide whether to stall next cycle.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.compare('{m_tdata, m_tuser[0], m_tlast, m_tuser[1]});
		m_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Abandon the run if neither side moves a transaction for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("** utf8_to_gb2312_stream: FAILED **");
		$finish;
	end

	function automatic bit maybe_last();
		return $urandom_range(99) < last_pct;
	endfunction

	// Present one input transaction after a random gap; hold it until accepted, then note it.
	task automatic send_item(logic cmd, logic [7:0] b, logic last, logic [IDX_W-1:0] idx,
			logic [KEY_W-1:0] key, logic [CODE_W-1:0] val);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tlast  <= last;
		s_tdata  <= {3'b000, val, key, idx, b};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.absorb(cmd, b, last, idx, key, val);
		items_sent++;
	endtask

	// Data byte: fill the unused load fields with noise, the block must ignore them.
	task automatic send_byte(logic [7:0] b, logic last);
		send_item(CMD_DATA, b, last, IDX_W'($urandom), KEY_W'($urandom), CODE_W'($urandom));
	endtask

	// Table load: last_byte and data_byte are don't-care here, so randomise them.
	task automatic send_load(logic [IDX_W-1:0] idx, logic [KEY_W-1:0] key,
			logic [CODE_W-1:0] val);
		send_item(CMD_LOAD, 8'($urandom), 1'($urandom), idx, key, val);
	endtask

	// Encode a code point as three bytes; with messy set the continuation markers are random.
	task automatic send_three(logic [15:0] key, bit messy);
		logic [1:0] mark_a, mark_b;
		mark_a = messy ? 2'($urandom) : 2'b10;
		mark_b = messy ? 2'($urandom) : 2'b10;
		send_byte({4'hE, key[15:12]}, maybe_last());
		send_byte({mark_a, key[11:6]}, maybe_last());
		send_byte({mark_b, key[5:0]}, maybe_last());
	endtask

	// Drain to idle, let any search settle, then write the entry count.
	task automatic reconfigure(logic [CFG_W-1:0] v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.waiting() != 0)
			@(posedge clk);
		repeat (SEARCH_SLACK) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.entries = v;
	endtask

	// Mostly well-formed sequences with random content, plus loads, strays and noise.
	task automatic random_phase(int quota);
		int         start, pick, k, reach;
		logic [15:0] key;
		logic [7:0]  lead;
		start = items_sent;
		while (items_sent - start < quota) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				send_byte(8'($urandom_range(127)), maybe_last());
			end else if (pick < 32) begin
				send_byte({3'b110, 5'($urandom)}, maybe_last());
				send_byte(8'($urandom), maybe_last());
			end else if (pick < 62) begin
				// aim at a key inside the searched range so that most of these hit
				reach = tracker.span();
				key   = (reach > 0) ? tracker.keys[$urandom_range(reach - 1)] : 16'($urandom);
				send_three(key, $urandom_range(3) == 0);
			end else if (pick < 70) begin
				send_three(16'($urandom), 1'b1);
			end else if (pick < 76) begin
				// four to six leading ones: lead byte plus its dropped continuation bytes
				k    = $urandom_range(6, 4);
				lead = (8'hFF << (8 - k)) | (8'($urandom) & (8'h7F >> k));
				send_byte(lead, maybe_last());
				repeat (k - 1) send_byte(8'($urandom), maybe_last());
			end else if (pick < 82) begin
				send_byte($urandom_range(1) ? {2'b10, 6'($urandom)} : {7'h7F, 1'($urandom)},
					maybe_last());
			end else if (pick < 90) begin
				// rewrite a loaded entry, keeping the table sorted
				k = $urandom_range(FILL_ENTRIES - 1);
				send_load(IDX_W'(k), 16'(k * 8 + $urandom_range(7)), CODE_W'($urandom));
			end else if (pick < 92) begin
				send_load(IDX_W'($urandom), KEY_W'($urandom), CODE_W'($urandom));
			end else begin
				send_byte(8'($urandom), maybe_last());
			end
		end
	endtask

	initial begin : stimulus
		logic [CFG_W-1:0] counts [6];
		logic [15:0]      gap_key;
		int               lo, hi, mid, n_path;
		int               path [16];
		tracker = new();
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= CMD_DATA;
		s_tlast   <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: every three-byte sequence misses without reading the store.
		reconfigure(CFG_W'(0));
		send_byte(8'h00, 1'b0);          // zero byte passes as ASCII
		send_byte(8'h7F, 1'b0);
		send_byte(8'hC3, 1'b0);          // two-byte copy
		send_byte(8'hA9, 1'b0);
		send_three(16'h4E2D, 1'b0);      // miss
		send_byte(8'h80, 1'b0);          // stray continuation
		send_byte(8'hFF, 1'b0);          // eight leading ones
		send_byte(8'h41, 1'b1);          // terminator after ASCII

		// Fill the low entries with sorted keys; one slot carries a zero code.
		for (int i = 0; i < FILL_ENTRIES; i++)
			send_load(IDX_W'(i), 16'(i * 8 + $urandom_range(7)),
				(i == ZERO_SLOT) ? CODE_W'(0) : CODE_W'($urandom));

		// Count above the depth: load only the entries that a search always moving up
		// visits, with rising keys, then search for those keys or one above them all.
		lo     = 0;
		hi     = TABLE_DEPTH - 1;
		n_path = 0;
		while (lo <= hi) begin
			mid          = (lo + hi) / 2;
			path[n_path] = mid;
			send_load(IDX_W'(mid), 16'(32'hF000 + n_path * 16), CODE_W'($urandom));
			n_path++;
			lo = mid + 1;
		end
		reconfigure(CFG_W'(16383));
		send_three(tracker.keys[path[0]], 1'b0);            // hit on the first probe
		send_three(tracker.keys[path[n_path - 1]], 1'b1);   // hit on the deepest probe
		send_three(tracker.keys[path[n_path / 2]], 1'b0);
		send_three(16'hFFFF, 1'b0);                         // above every key: miss

		reconfigure(CFG_W'(FILL_ENTRIES));
		send_three(tracker.keys[ZERO_SLOT], 1'b0);          // hit with a zero code
		send_three(tracker.keys[FILL_ENTRIES - 1], 1'b1);   // top key, unchecked markers
		gap_key = (tracker.keys[10] == 16'd80) ? 16'd81 : 16'd80;
		send_three(gap_key, 1'b0);                          // miss between two keys
		send_byte(8'hF0, 1'b0);                             // four-byte sequence, dropped
		send_byte(8'h9F, 1'b0);
		send_byte(8'h98, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hE4, 1'b0);                             // unfinished at the end of string
		send_byte(8'hB8, 1'b1);

		// Random part over several entry counts within the loaded entries.
		counts[0] = CFG_W'(FILL_ENTRIES);
		counts[1] = CFG_W'(1);
		counts[2] = CFG_W'(FILL_ENTRIES);
		counts[3] = CFG_W'($urandom_range(FILL_ENTRIES - 1, 2));
		counts[4] = CFG_W'(2);
		counts[5] = CFG_W'($urandom_range(FILL_ENTRIES - 1, 2));
		last_pct  = 6;
		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				src_idle_pct = 71;
				snk_idle_pct = 14;
			end else if (p == 4) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			reconfigure(counts[p]);
			random_phase(PHASE_ITEMS);
		end

		// Drain, then allow for a late search before judging.
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.waiting() != 0)
			@(posedge clk);
		repeat (SEARCH_SLACK) @(posedge clk);
		if (tracker.errors == 0 && tracker.waiting() == 0) begin
			$display("** utf8_to_gb2312_stream: PASSED **");
		end else begin
			$display("** utf8_to_gb2312_stream: FAILED **");
		end
		$finish;
	end

endmodule
